### hdl/rrseek_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring seek package
// Shared types, codes and constants of the record ring with offset seek.
// ----------------------------------------------------------------------------
package rrseek_pkg;

    // Default configuration of the ring.
    localparam int DEF_SLOTS     = 10;
    localparam int DEF_SIZE_BITS = 20;

    // Fixed field widths of the request and result ports.
    localparam int REQ_W  = 2;
    localparam int REC_W  = 20;
    localparam int FLAT_W = 24;
    localparam int CIDX_W = 4;
    localparam int SLOT_W = 4;

    // Largest flat byte position that a result can carry.
    localparam logic [FLAT_W-1:0] FLAT_MAX = {FLAT_W{1'b1}};

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD       = 2'd0,
        REQ_BYTE_SEEK = 2'd1,
        REQ_CMD_SEEK  = 2'd2,
        REQ_BAD       = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } t_state;

    // Seek request broadcast to every cell, with the current walk step.
    typedef struct packed {
        t_req_type          mode;
        logic [FLAT_W-1:0]  target;
        logic [CIDX_W-1:0]  idx;
        logic [REC_W-1:0]   off;
        logic [SLOT_W-1:0]  step;
    } t_seek;

    // Outcome reported by the cell that holds the walk token.
    typedef struct packed {
        logic               done;
        logic               status;
        logic [SLOT_W-1:0]  slot;
        logic [REC_W-1:0]   off;
        logic [FLAT_W-1:0]  flat;
    } t_res;

endpackage

### hdl/rrseek_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring seek cell
// Holds the size of one ring slot and, during a seek, the walk token with
// the running byte sum, which it passes on to the next slot.
// ----------------------------------------------------------------------------
module rrseek_cell #(
    parameter int SIZE_BITS = 20,
    parameter int SUM_W     = 26,
    parameter int SLOTS     = 10,
    parameter int CELL_ID   = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [SIZE_BITS-1:0]  i_wr_size,
    input  rrseek_pkg::t_seek     i_seek,
    input  logic                  i_tok_vld,
    input  logic [SUM_W-1:0]      i_tok_sum,
    output logic                  o_tok_vld,
    output logic [SUM_W-1:0]      o_tok_sum,
    output logic                  o_busy,
    output rrseek_pkg::t_res      o_res
);
    import rrseek_pkg::*;

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_tok_vld;
    logic [SUM_W-1:0]     r_tok_sum;

    logic [SUM_W-1:0] w_size;
    logic [SUM_W-1:0] w_sum_nx;
    logic [SUM_W-1:0] w_target;
    logic [SUM_W-1:0] w_off;
    logic [SUM_W-1:0] w_flat;
    logic             w_done;

    assign w_size   = SUM_W'(r_size);
    assign w_sum_nx = r_tok_sum + w_size;
    assign w_target = SUM_W'(i_seek.target);
    assign w_off    = SUM_W'(i_seek.off);
    assign w_flat   = r_tok_sum + w_off;

    always_comb begin
        o_res  = '0;
        w_done = 1'b0;
        if (r_tok_vld) begin
            if (i_seek.mode == REQ_CMD_SEEK) begin
                // The requested record is reached after idx steps.
                if (i_seek.step == i_seek.idx) begin
                    w_done      = 1'b1;
                    o_res.done  = 1'b1;
                    if (w_off < w_size && w_flat <= SUM_W'(FLAT_MAX)) begin
                        o_res.status = STATUS_OK;
                        o_res.slot   = SLOT_W'(CELL_ID);
                        o_res.off    = i_seek.off;
                        o_res.flat   = FLAT_W'(w_flat);
                    end else begin
                        o_res.status = STATUS_FAIL;
                    end
                end
            end else begin
                if (w_sum_nx > w_target) begin
                    w_done       = 1'b1;
                    o_res.done   = 1'b1;
                    o_res.status = STATUS_OK;
                    o_res.slot   = SLOT_W'(CELL_ID);
                    o_res.off    = REC_W'(w_target - r_tok_sum);
                end else if (i_seek.step == SLOT_W'(SLOTS - 1)) begin
                    // Last slot of the ring passed without a hit.
                    w_done       = 1'b1;
                    o_res.done   = 1'b1;
                    o_res.status = STATUS_FAIL;
                end
            end
        end
    end

    assign o_tok_vld = r_tok_vld & ~w_done;
    assign o_tok_sum = w_sum_nx;
    assign o_busy    = r_tok_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_size <= i_wr_size;
            end
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_sum <= i_tok_sum;
    end

endmodule

### hdl/write_record_ring_with_offset_seek_core.sv
`timescale 1ns / 1ps
// An add or a rejected request goes from acceptance into the result register and then into
// the output register; a seek walks its token around the ring until a cell reports, then
// its result takes the same path. One request is handled at a time: the next is taken only
// once the result has moved into the output register, which result stalls can hold off.
// Reset (synchronous, active low) clears all sizes, both slot pointers and the full flag;
// requests are taken once reset is released.
// ----------------------------------------------------------------------------
// Record ring with offset seek
// A ring of record sizes built as a chain of slot cells. Seeks move a token
// with a running byte sum around the chain, starting at the oldest slot.
// ----------------------------------------------------------------------------
module write_record_ring_with_offset_seek_core #(
    parameter int SLOTS     = rrseek_pkg::DEF_SLOTS,
    parameter int SIZE_BITS = rrseek_pkg::DEF_SIZE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rrseek_pkg::REQ_W-1:0]     i_req_type,
    input  logic [rrseek_pkg::REC_W-1:0]     i_entry_size,
    input  logic                             i_complete,
    input  logic                             i_starts_new,
    input  logic [rrseek_pkg::FLAT_W-1:0]    i_byte_offset,
    input  logic [rrseek_pkg::CIDX_W-1:0]    i_cmd_index,
    input  logic [rrseek_pkg::REC_W-1:0]     i_cmd_offset,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_status,
    output logic [rrseek_pkg::SLOT_W-1:0]    o_slot,
    output logic [rrseek_pkg::REC_W-1:0]     o_offset_in_record,
    output logic [rrseek_pkg::FLAT_W-1:0]    o_flat_offset
);
    import rrseek_pkg::*;

    // Slot pointer width, and a running sum wide enough for a full ring and
    // for comparison against any flat byte position.
    localparam int IDX_W = $clog2(SLOTS);
    localparam int SUM_W = (SIZE_BITS + 5 > FLAT_W + 2) ? SIZE_BITS + 5 : FLAT_W + 2;

    // Control state.
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_wr, n_wr;
    logic [IDX_W-1:0]  r_rd, n_rd;
    logic              r_full, n_full;
    t_seek             r_seek, n_seek;
    t_res              r_res, n_res;

    // Output register.
    logic              r_o_valid, n_o_valid;
    logic              r_o_status, n_o_status;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    logic [REC_W-1:0]  r_o_off, n_o_off;
    logic [FLAT_W-1:0] r_o_flat, n_o_flat;

    // Chain signals.
    logic                 w_wr_en;
    logic                 w_inject;
    logic [SIZE_BITS-1:0] w_wr_size;
    logic [SLOTS-1:0]     w_cell_wr;
    logic [SLOTS-1:0]     w_tok_in_vld;
    logic [SLOTS-1:0]     w_tok_out_vld;
    logic [SLOTS-1:0]     w_busy;
    logic [SUM_W-1:0]     w_tok_in_sum  [SLOTS];
    logic [SUM_W-1:0]     w_tok_out_sum [SLOTS];
    t_res                 w_cell_res    [SLOTS];
    t_res                 w_res;

    // Add bookkeeping.
    t_req_type        w_req;
    logic [IDX_W-1:0] w_rd_adv;
    logic [IDX_W-1:0] w_wr_adv;
    logic             w_idx_ok;
    logic             w_accept;

    assign w_req     = t_req_type'(i_req_type);
    assign w_accept  = i_valid && (r_state == ST_IDLE);
    assign w_wr_size = SIZE_BITS'(i_entry_size);
    assign w_idx_ok  = ({1'b0, i_cmd_index} < (CIDX_W + 1)'(SLOTS));
    assign w_wr_en   = w_accept && (w_req == REQ_ADD);
    assign w_inject  = w_accept && ((w_req == REQ_BYTE_SEEK) ||
                                    (w_req == REQ_CMD_SEEK && w_idx_ok));

    // The oldest slot is dropped only when a new record starts on a full ring;
    // the full flag is then computed against the already advanced read slot.
    assign w_rd_adv = (i_starts_new && r_full) ?
                      ((r_rd == IDX_W'(SLOTS - 1)) ? '0 : r_rd + 1'b1) : r_rd;
    assign w_wr_adv = (r_wr == IDX_W'(SLOTS - 1)) ? '0 : r_wr + 1'b1;

    // The slot cells form a ring. A seek drops a token with a zero sum into
    // the cell of the oldest slot; from there it moves one cell per cycle.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? SLOTS - 1 : g - 1;

        always_comb begin
            w_cell_wr[g] = w_wr_en && (r_wr == IDX_W'(g));
            if (w_inject && r_rd == IDX_W'(g)) begin
                w_tok_in_vld[g] = 1'b1;
                w_tok_in_sum[g] = '0;
            end else begin
                w_tok_in_vld[g] = w_tok_out_vld[PREV];
                w_tok_in_sum[g] = w_tok_out_sum[PREV];
            end
        end

        rrseek_cell #(
            .SIZE_BITS (SIZE_BITS),
            .SUM_W     (SUM_W),
            .SLOTS     (SLOTS),
            .CELL_ID   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_cell_wr[g]),
            .i_wr_size (w_wr_size),
            .i_seek    (r_seek),
            .i_tok_vld (w_tok_in_vld[g]),
            .i_tok_sum (w_tok_in_sum[g]),
            .o_tok_vld (w_tok_out_vld[g]),
            .o_tok_sum (w_tok_out_sum[g]),
            .o_busy    (w_busy[g]),
            .o_res     (w_cell_res[g])
        );
    end

    // Only the cell holding the token reports anything, so the results of
    // all cells can simply be merged.
    always_comb begin
        w_res = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_res = t_res'(w_res | w_cell_res[i]);
        end
    end

    // Requests are taken only in the idle state, while no walk runs and no result waits.
    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_full     = r_full;
        n_seek     = r_seek;
        n_res      = r_res;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_off    = r_o_off;
        n_o_flat   = r_o_flat;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_res        = '0;
                    n_res.done   = 1'b1;
                    n_res.status = STATUS_FAIL;
                    n_seek.mode   = w_req;
                    n_seek.target = i_byte_offset;
                    n_seek.idx    = i_cmd_index;
                    n_seek.off    = i_cmd_offset;
                    n_seek.step   = '0;
                    unique case (w_req)
                        REQ_ADD: begin
                            n_rd         = w_rd_adv;
                            n_res.status = STATUS_OK;
                            if (i_complete) begin
                                n_wr   = w_wr_adv;
                                n_full = (w_wr_adv == w_rd_adv);
                            end
                            n_state = ST_RESULT;
                        end
                        REQ_BYTE_SEEK: begin
                            n_state = ST_WALK;
                        end
                        REQ_CMD_SEEK: begin
                            n_state = w_idx_ok ? ST_WALK : ST_RESULT;
                        end
                        REQ_BAD: begin
                            n_state = ST_RESULT;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (w_res.done) begin
                    n_res   = w_res;
                    n_state = ST_RESULT;
                end else begin
                    n_seek.step = r_seek.step + 1'b1;
                end
            end
            ST_RESULT: begin
                // The result moves out once the output register is free
                // or is being emptied in this cycle.
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res.status;
                    n_o_slot   = r_res.slot;
                    n_o_off    = r_res.off;
                    n_o_flat   = r_res.flat;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr      <= '0;
            r_rd      <= '0;
            r_full    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr      <= n_wr;
            r_rd      <= n_rd;
            r_full    <= n_full;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seek     <= n_seek;
        r_res      <= n_res;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_off    <= n_o_off;
        r_o_flat   <= n_o_flat;
    end

    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_slot             = r_o_slot;
    assign o_offset_in_record = r_o_off;
    assign o_flat_offset      = r_o_flat;

    // At most one walk token exists anywhere on the ring.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_busy))
        else $error("more than one walk token on the ring");

    // While walking, the token is held by exactly one cell.
    a_walk_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> $onehot(w_busy))
        else $error("walk running without a token");

    // Both slot pointers always name a slot of the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wr} < (IDX_W + 1)'(SLOTS)) && ({1'b0, r_rd} < (IDX_W + 1)'(SLOTS)))
        else $error("slot pointer outside the ring");

    // A walk never runs past the last slot of the ring.
    a_walk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ({1'b0, r_seek.step} < (SLOT_W + 1)'(SLOTS)))
        else $error("walk step beyond ring length");

endmodule
